/* hdl/c8_pkg.sv */
// Shared types, codes and the hex font table of the CHIP-8 instruction core.
package c8_pkg;

  typedef enum logic [1:0] {
    OP_EXEC   = 2'd0,
    OP_TICK   = 2'd1,
    OP_MWRITE = 2'd2,
    OP_PREAD  = 2'd3
  } op_t;

  localparam logic [11:0] RESET_PC = 12'h200;
  localparam int          FONT_LEN = 80;

  // Instruction groups by top nibble.
  localparam logic [3:0] G_SYS  = 4'h0;
  localparam logic [3:0] G_JP   = 4'h1;
  localparam logic [3:0] G_CALL = 4'h2;
  localparam logic [3:0] G_SEI  = 4'h3;
  localparam logic [3:0] G_SNEI = 4'h4;
  localparam logic [3:0] G_SER  = 4'h5;
  localparam logic [3:0] G_LDI  = 4'h6;
  localparam logic [3:0] G_ADDI = 4'h7;
  localparam logic [3:0] G_ALU  = 4'h8;
  localparam logic [3:0] G_SNER = 4'h9;
  localparam logic [3:0] G_LDIX = 4'hA;
  localparam logic [3:0] G_JPV0 = 4'hB;
  localparam logic [3:0] G_RND  = 4'hC;
  localparam logic [3:0] G_DRW  = 4'hD;
  localparam logic [3:0] G_MISC = 4'hF;

  localparam logic [7:0] SYS_CLS = 8'hE0;
  localparam logic [7:0] SYS_RET = 8'hEE;
  localparam logic [7:0] MISC_GETDT = 8'h07;
  localparam logic [7:0] MISC_SETDT = 8'h15;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_RSB = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  function automatic logic [7:0] font_byte(input logic [6:0] i);
    logic [7:0] b;
    case (i)
      7'd0, 7'd4, 7'd10, 7'd12, 7'd14, 7'd15, 7'd17, 7'd19, 7'd22, 7'd25,
      7'd27, 7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd40, 7'd42, 7'd44, 7'd45,
      7'd47, 7'd49, 7'd50, 7'd52, 7'd60, 7'd64, 7'd70, 7'd72, 7'd74, 7'd75,
      7'd77: b = 8'hF0;
      7'd1, 7'd2, 7'd3, 7'd20, 7'd21, 7'd33, 7'd41, 7'd43, 7'd46, 7'd51,
      7'd53, 7'd54, 7'd56, 7'd58, 7'd66, 7'd67, 7'd68: b = 8'h90;
      7'd5, 7'd7, 7'd8, 7'd37: b = 8'h20;
      7'd6: b = 8'h60;
      7'd9: b = 8'h70;
      7'd11, 7'd16, 7'd18, 7'd23, 7'd24, 7'd28, 7'd36, 7'd48: b = 8'h10;
      7'd13, 7'd26, 7'd31, 7'd61, 7'd62, 7'd63, 7'd71, 7'd73, 7'd76, 7'd78,
      7'd79: b = 8'h80;
      7'd38, 7'd39: b = 8'h40;
      7'd55, 7'd57, 7'd59, 7'd65, 7'd69: b = 8'hE0;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* hdl/c8_if.sv */
// Valid/ready channel interfaces for the input items and the result items.
interface c8_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [11:0] address;
  logic [7:0]  write_data;
  logic [7:0]  random_byte;
  modport source (output valid, op, address, write_data, random_byte, input ready);
  modport sink (input valid, op, address, write_data, random_byte, output ready);
endinterface

interface c8_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] program_counter;
  logic [15:0] opcode;
  logic        pixel_value;
  logic        display_changed;
  logic [7:0]  delay_value;
  modport source (output valid, program_counter, opcode, pixel_value, display_changed,
                  delay_value, input ready);
  modport sink (input valid, program_counter, opcode, pixel_value, display_changed,
                delay_value, output ready);
endinterface

/* hdl/c8_ram.sv */
// Generic one-write, one-read synchronous RAM with registered read data.
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/c8_div.sv */
// Divider by a constant: compare and subtract against shifted copies of the divisor.
module c8_div #(
  parameter int DW      = 12,
  parameter int VW      = 8,
  parameter int DIVISOR = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem
);
  logic          done_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] quot_r;
  logic [DW-1:0] rem_nxt;
  logic [DW-1:0] quot_nxt;

  // Shifts of the divisor wider than the dividend never compare true and drop out.
  always_comb begin
    rem_nxt  = dividend;
    quot_nxt = '0;
    for (int k = DW - 1; k >= 0; k--) begin
      if (longint'(rem_nxt) >= (longint'(DIVISOR) << k)) begin
        rem_nxt     = rem_nxt - DW'(longint'(DIVISOR) << k);
        quot_nxt[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
      if (start) begin
        rem_r  <= rem_nxt;
        quot_r <= quot_nxt;
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r[VW-1:0];
endmodule

/* hdl/chip8_instruction_core.sv */
// Top level of the CHIP-8 instruction core: sequencer, registers and both memories.
//
//   channel  direction  beat contents
//   in_bus   input      op, address, write_data, random_byte
//   out_bus  output     program_counter, opcode, pixel_value, display_changed, delay_value
//   cfg_*    input      start address write, no handshake
//
// After reset the main memory is swept once, one byte a cycle, to load the font and
// zero the rest, with in_bus.ready low. An instruction passes S_FETCH0 to S_FETCH2,
// S_RDX, S_RDY, S_EXEC and S_FINISH; a pixel read out of range skips the division and
// the frame buffer read. A draw passes S_DROW and S_DXOR once per drawn sprite row.
// A result that cannot leave holds the core in S_FINISH; a new beat is taken while
// the previous result still waits at out_bus.
module chip8_instruction_core
  import c8_pkg::*;
#(
  parameter int MEM_DEPTH     = 4096,
  parameter int SCREEN_WIDTH  = 64,
  parameter int SCREEN_HEIGHT = 32,
  parameter int STACK_DEPTH   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  c8_in_if.sink       in_bus,
  c8_out_if.source    out_bus
);
  localparam int AW     = $clog2(MEM_DEPTH);
  localparam int CW     = $clog2(SCREEN_WIDTH);
  localparam int RW     = $clog2(SCREEN_HEIGHT);
  localparam int SW     = $clog2(STACK_DEPTH);
  localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_MWRITE, S_PDIV, S_PREAD, S_PDATA, S_FETCH0, S_FETCH1,
    S_FETCH2, S_RDX, S_RDY, S_EXEC, S_DROW, S_DXOR, S_FINISH
  } state_t;

  function automatic logic [AW-1:0] mem_idx(input logic [11:0] a);
    logic [16:0] v;
    v = 17'(a);
    for (int i = 0; i < 8; i++) begin
      if (v >= 17'(MEM_DEPTH)) begin
        v = v - 17'(MEM_DEPTH);
      end
    end
    return v[AW-1:0];
  endfunction

  // Reduces a register value modulo a screen dimension by compare and subtract.
  function automatic logic [7:0] coord_mod(input logic [7:0] a, input int m);
    logic [7:0] r;
    r = a;
    for (int k = 7; k >= 0; k--) begin
      if (longint'(r) >= (longint'(m) << k)) begin
        r = r - 8'(longint'(m) << k);
      end
    end
    return r;
  endfunction

  state_t                  state_r;
  logic [AW:0]             clr_r;
  logic [11:0]             addr_r;
  logic [7:0]              wdata_r;
  logic [7:0]              rnd_r;
  logic [11:0]             pc_r;
  logic [11:0]             idx_r;
  logic [SW-1:0]           sp_r;
  logic [7:0]              dt_r;
  logic [7:0]              v_r [16];
  logic [11:0]             stk_r [STACK_DEPTH];
  logic [SCREEN_HEIGHT-1:0] fb_vld_r;
  logic [7:0]              hi_r;
  logic [15:0]             ins_r;
  logic [7:0]              vx_r;
  logic [7:0]              vy_r;
  logic [15:0]             word_r;
  logic                    pix_r;
  logic                    chg_r;
  logic                    hit_r;
  logic [4:0]              row_cnt_r;
  logic [CW-1:0]           px_r;
  logic [RW-1:0]           py_r;
  logic [RW-1:0]           fb_row_r;
  logic [CW-1:0]           col_r;
  logic                    div_go_r;
  logic [11:0]             div_a_r;
  logic                    out_valid_r;
  logic [11:0]             out_pc_r;
  logic [15:0]             out_op_r;
  logic                    out_pix_r;
  logic                    out_chg_r;
  logic [7:0]              out_dt_r;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [7:0]              mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [7:0]              mem_rdata;
  logic                    fb_we;
  logic [SCREEN_WIDTH-1:0] fb_wdata;
  logic [RW-1:0]           fb_raddr;
  logic [SCREEN_WIDTH-1:0] fb_rdata;
  logic                    div_done;
  logic [11:0]             div_quot;
  logic [7:0]              div_rem;
  logic [3:0]              rf_raddr;
  logic [7:0]              rf_rd;
  logic [7:0]              row_lim;
  logic [SCREEN_WIDTH-1:0] cur_row;
  logic [SCREEN_WIDTH-1:0] pat_row;
  logic [SCREEN_WIDTH+7:0] pat_wide;
  logic [7:0]              sprite_rev;
  logic [SW-1:0]           sp_inc;
  logic [SW-1:0]           sp_dec;
  logic [11:0]             pc2;
  logic [11:0]             pc4;
  logic [8:0]              add9;
  logic                    out_free;

  c8_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  c8_ram #(.WIDTH(SCREEN_WIDTH), .DEPTH(SCREEN_HEIGHT)) u_fb (
    .clk(clk), .we(fb_we), .waddr(fb_row_r), .wdata(fb_wdata),
    .raddr(fb_raddr), .rdata(fb_rdata)
  );

  c8_div #(.DW(12), .VW(8), .DIVISOR(SCREEN_WIDTH)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go_r), .dividend(div_a_r),
    .done(div_done), .quot(div_quot), .rem(div_rem)
  );

  assign rf_rd    = v_r[rf_raddr];
  assign row_lim  = 8'(py_r) + 8'(row_cnt_r);
  assign sp_inc   = (sp_r == SW'(STACK_DEPTH - 1)) ? '0 : sp_r + 1'b1;
  assign sp_dec   = (sp_r == '0) ? SW'(STACK_DEPTH - 1) : sp_r - 1'b1;
  assign pc2      = pc_r + 12'd2;
  assign pc4      = pc_r + 12'd4;
  assign add9     = 9'(vx_r) + 9'(vy_r);
  assign out_free = !out_valid_r || out_bus.ready;

  // Sprite bit 7 lands on the leftmost column; shifting past the edge clips it.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      sprite_rev[b] = mem_rdata[7-b];
    end
    pat_wide = (SCREEN_WIDTH + 8)'(sprite_rev) << px_r;
    pat_row  = pat_wide[SCREEN_WIDTH-1:0];
    cur_row  = fb_vld_r[fb_row_r] ? fb_rdata : '0;
    fb_wdata = cur_row ^ pat_row;
    fb_we    = (state_r == S_DXOR);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_r[AW-1:0];
    mem_wdata = (clr_r < (AW+1)'(FONT_LEN)) ? font_byte(clr_r[6:0]) : 8'h00;
    mem_raddr = mem_idx(pc_r);
    fb_raddr  = row_lim[RW-1:0];
    rf_raddr  = ins_r[11:8];
    case (state_r)
      S_CLEAR:  mem_we = (clr_r != (AW+1)'(MEM_DEPTH));
      S_MWRITE: begin
        mem_we    = 1'b1;
        mem_waddr = mem_idx(addr_r);
        mem_wdata = wdata_r;
      end
      S_FETCH1: mem_raddr = mem_idx(pc_r + 12'd1);
      S_DROW:   mem_raddr = mem_idx(idx_r + 12'(row_cnt_r));
      S_PREAD:  fb_raddr  = fb_row_r;
      S_RDY:    rf_raddr  = (ins_r[15:12] == G_JPV0) ? 4'd0 : ins_r[7:4];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pc_r        <= RESET_PC;
      idx_r       <= '0;
      sp_r        <= '0;
      dt_r        <= '0;
      fb_vld_r    <= '0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        v_r[i] <= '0;
      end
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stk_r[i] <= '0;
      end
    end else begin
      div_go_r <= 1'b0;
      if (out_valid_r && out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        pc_r <= cfg_wdata;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (clr_r == (AW+1)'(MEM_DEPTH)) begin
            state_r <= S_IDLE;
          end else begin
            clr_r <= clr_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_bus.valid) begin
            addr_r  <= in_bus.address;
            wdata_r <= in_bus.write_data;
            rnd_r   <= in_bus.random_byte;
            word_r  <= '0;
            pix_r   <= 1'b0;
            chg_r   <= 1'b0;
            unique case (op_t'(in_bus.op))
              OP_EXEC:   state_r <= S_FETCH0;
              OP_TICK: begin
                if (dt_r != '0) begin
                  dt_r <= dt_r - 1'b1;
                end
                state_r <= S_FINISH;
              end
              OP_MWRITE: state_r <= S_MWRITE;
              OP_PREAD: begin
                if (32'(in_bus.address) < 32'(PIXELS)) begin
                  div_go_r <= 1'b1;
                  div_a_r  <= in_bus.address;
                  state_r  <= S_PDIV;
                end else begin
                  state_r <= S_FINISH;
                end
              end
              default: state_r <= S_FINISH;
            endcase
          end
        end
        S_MWRITE: state_r <= S_FINISH;
        S_PDIV: begin
          if (div_done) begin
            fb_row_r <= div_quot[RW-1:0];
            col_r    <= div_rem[CW-1:0];
            state_r  <= S_PREAD;
          end
        end
        S_PREAD: state_r <= S_PDATA;
        S_PDATA: begin
          pix_r   <= fb_vld_r[fb_row_r] & fb_rdata[col_r];
          state_r <= S_FINISH;
        end
        S_FETCH0: state_r <= S_FETCH1;
        S_FETCH1: begin
          hi_r    <= mem_rdata;
          state_r <= S_FETCH2;
        end
        S_FETCH2: begin
          ins_r   <= {hi_r, mem_rdata};
          state_r <= S_RDX;
        end
        S_RDX: begin
          vx_r    <= rf_rd;
          state_r <= S_RDY;
        end
        S_RDY: begin
          vy_r    <= rf_rd;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          word_r  <= ins_r;
          pc_r    <= pc2;
          state_r <= S_FINISH;
          unique case (ins_r[15:12])
            G_SYS: begin
              if (ins_r[7:0] == SYS_CLS) begin
                fb_vld_r <= '0;
                chg_r    <= 1'b1;
              end else if (ins_r[7:0] == SYS_RET) begin
                sp_r <= sp_dec;
                pc_r <= stk_r[sp_dec];
              end
            end
            G_JP: pc_r <= ins_r[11:0];
            G_CALL: begin
              stk_r[sp_r] <= pc2;
              sp_r        <= sp_inc;
              pc_r        <= ins_r[11:0];
            end
            G_SEI:  if (vx_r == ins_r[7:0]) pc_r <= pc4;
            G_SNEI: if (vx_r != ins_r[7:0]) pc_r <= pc4;
            G_SER:  if (vx_r == vy_r) pc_r <= pc4;
            G_LDI:  v_r[ins_r[11:8]] <= ins_r[7:0];
            G_ADDI: v_r[ins_r[11:8]] <= vx_r + ins_r[7:0];
            G_ALU: begin
              // The flag is written after the result so that VF keeps the flag.
              case (ins_r[3:0])
                ALU_MOV: v_r[ins_r[11:8]] <= vy_r;
                ALU_OR:  v_r[ins_r[11:8]] <= vx_r | vy_r;
                ALU_AND: v_r[ins_r[11:8]] <= vx_r & vy_r;
                ALU_XOR: v_r[ins_r[11:8]] <= vx_r ^ vy_r;
                ALU_ADD: begin
                  v_r[ins_r[11:8]] <= add9[7:0];
                  v_r[15]          <= 8'(add9[8]);
                end
                ALU_SUB: begin
                  v_r[ins_r[11:8]] <= vx_r - vy_r;
                  v_r[15]          <= 8'(vx_r >= vy_r);
                end
                ALU_SHR: begin
                  v_r[ins_r[11:8]] <= vy_r >> 1;
                  v_r[15]          <= 8'(vy_r[0]);
                end
                ALU_RSB: begin
                  v_r[ins_r[11:8]] <= vy_r - vx_r;
                  v_r[15]          <= 8'(vy_r >= vx_r);
                end
                ALU_SHL: begin
                  v_r[ins_r[11:8]] <= vy_r << 1;
                  v_r[15]          <= 8'(vy_r[7]);
                end
                default: ;
              endcase
            end
            G_SNER: if (vx_r != vy_r) pc_r <= pc4;
            G_LDIX: idx_r <= ins_r[11:0];
            G_JPV0: pc_r <= ins_r[11:0] + 12'(vy_r);
            G_RND:  v_r[ins_r[11:8]] <= rnd_r & ins_r[7:0];
            G_DRW: begin
              px_r      <= CW'(coord_mod(vx_r, SCREEN_WIDTH));
              py_r      <= RW'(coord_mod(vy_r, SCREEN_HEIGHT));
              row_cnt_r <= '0;
              hit_r     <= 1'b0;
              state_r   <= S_DROW;
            end
            G_MISC: begin
              if (ins_r[7:0] == MISC_GETDT) begin
                v_r[ins_r[11:8]] <= dt_r;
              end else if (ins_r[7:0] == MISC_SETDT) begin
                dt_r <= vx_r;
              end
            end
            default: ;
          endcase
        end
        S_DROW: begin
          if (row_cnt_r == 5'(ins_r[3:0]) || row_lim >= 8'(SCREEN_HEIGHT)) begin
            v_r[15] <= 8'(hit_r);
            chg_r   <= 1'b1;
            state_r <= S_FINISH;
          end else begin
            fb_row_r <= row_lim[RW-1:0];
            state_r  <= S_DXOR;
          end
        end
        S_DXOR: begin
          fb_vld_r[fb_row_r] <= 1'b1;
          hit_r              <= hit_r | (|(cur_row & pat_row));
          row_cnt_r          <= row_cnt_r + 1'b1;
          state_r            <= S_DROW;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_pc_r    <= pc_r;
            out_op_r    <= word_r;
            out_pix_r   <= pix_r;
            out_chg_r   <= chg_r;
            out_dt_r    <= dt_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_bus.ready            = (state_r == S_IDLE);
  assign out_bus.valid           = out_valid_r;
  assign out_bus.program_counter = out_pc_r;
  assign out_bus.opcode          = out_op_r;
  assign out_bus.pixel_value     = out_pix_r;
  assign out_bus.display_changed = out_chg_r;
  assign out_bus.delay_value     = out_dt_r;
endmodule
